// ===== rtl/spa_pkg.sv =====
// Shared types and constants for the slot pool allocator.
// No dependencies; imported by the top level.
package spa_pkg;

   localparam int SLOT_W       = 6;   // width of slot fields on the request/response ports
   localparam int CFG_W        = 7;   // width of the active slot count CSR write data
   localparam int ACTIVE_RESET = 64;  // active slot count after reset

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_MARK  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_WALK,
      ST_WEND,
      ST_HOLD
   } state_type;

endpackage

// ===== rtl/slot_pool_allocator_lazy_reclaim.sv =====
// Slot pool allocator: LIFO free and used lists linked through a link RAM, with lazy reclaim.
// Depends on spa_pkg (types, constants) and spa_ram (link and mark storage).
//
// Usage:
//   Request channel (req_valid/req_ready) carries either an allocate or a mark
//   write (req_type). Each request yields exactly one transfer on the response
//   channel (rsp_valid/rsp_ready): rsp_ok and rsp_granted_slot.
//   csr_wr_en/csr_wr_data set the active slot count (saturated to NUM_SLOTS) and
//   rebuild the pool; write it only while the block is idle.
//
// Sequencing and throughput:
//   Mark writes and allocations from slots never handed out since the last
//   rebuild finish in the accept cycle and land in the output register: one
//   item per cycle while the output is not stalled. An allocation from the
//   reclaimed free list reads the link RAM in the accept cycle and finishes
//   in ST_POP. When the free list is empty, the used list is walked one entry
//   per cycle (link and mark RAM read latency bound the loop) in ST_WALK, then
//   ST_WEND and, if any slot was reclaimed, ST_POP. Requests are not accepted during a walk.
// Reset:
//   Synchronous; afterwards the pool holds min(64, NUM_SLOTS) slots, all free.
//   The RAMs need no clearing pass: untouched slots are tracked by a count.
// Stall:
//   A finished response waits in the output register; one further result is
//   parked in a holding register, and then the request side stops.
module slot_pool_allocator_lazy_reclaim #(
   parameter int NUM_SLOTS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_type,
   input  logic [spa_pkg::SLOT_W-1:0] req_slot_index,
   input  logic                       req_referenced,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_ok,
   output logic [spa_pkg::SLOT_W-1:0] rsp_granted_slot,
   input  logic                       csr_wr_en,
   input  logic [spa_pkg::CFG_W-1:0]  csr_wr_data
);
   import spa_pkg::*;

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int LW = $clog2(NUM_SLOTS + 1);
   localparam int CW = (LW > CFG_W) ? LW : CFG_W;
   localparam logic [LW-1:0] LINK_NULL  = LW'(NUM_SLOTS);
   localparam logic [LW-1:0] ACTIVE_RST =
      (ACTIVE_RESET > NUM_SLOTS) ? LW'(NUM_SLOTS) : LW'(ACTIVE_RESET);

   state_type state_ff, state_in;

   logic [LW-1:0]     active_ff, active_in;
   logic [LW-1:0]     fresh_cnt_ff, fresh_cnt_in;   // slots below this were never handed out
   logic [LW-1:0]     free_head_ff, free_head_in;
   logic [LW-1:0]     used_head_ff, used_head_in;
   logic [LW-1:0]     cur_ff, cur_in;
   logic [LW-1:0]     kept_ff, kept_in;             // last referenced slot kept during a walk
   logic              kept_valid_ff, kept_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              hold_ok_ff, hold_ok_in;
   logic [SLOT_W-1:0] hold_slot_ff, hold_slot_in;

   logic              link_we, link_re, mark_we, mark_re, mark_wd;
   logic [SW-1:0]     link_wa, link_ra, mark_wa, mark_ra;
   logic [LW-1:0]     link_wd, link_rd;
   logic              mark_rd;

   logic              req_fire, out_free, is_mark, idx_ok;
   logic              fresh_any, free_any, used_any, walk_last;
   logic              fin, fin_ok;
   logic [SLOT_W-1:0] fin_slot;
   logic [LW-1:0]     fresh_slot;
   logic [CW-1:0]     cfg_ext;
   logic [LW-1:0]     cfg_sat;

   spa_ram #(.DEPTH(NUM_SLOTS), .WIDTH(LW), .AW(SW)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (link_re),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   spa_ram #(.DEPTH(NUM_SLOTS), .WIDTH(1), .AW(SW)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_wa),
      .wr_data (mark_wd),
      .rd_en   (mark_re),
      .rd_addr (mark_ra),
      .rd_data (mark_rd)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid & req_ready;
   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign is_mark    = (req_type == REQ_MARK);
   assign idx_ok     = CW'(req_slot_index) < CW'(active_ff);
   assign fresh_any  = (fresh_cnt_ff != '0);
   assign free_any   = (free_head_ff != LINK_NULL);
   assign used_any   = (used_head_ff != LINK_NULL);
   assign walk_last  = (link_rd == LINK_NULL);
   assign fresh_slot = fresh_cnt_ff - LW'(1);
   assign cfg_ext    = CW'(csr_wr_data);
   assign cfg_sat    = (cfg_ext > CW'(NUM_SLOTS)) ? LINK_NULL : LW'(cfg_ext);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (is_mark || fresh_any) begin
                  state_in = out_free ? ST_IDLE : ST_HOLD;
               end else if (free_any) begin
                  state_in = ST_POP;
               end else if (used_any) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = out_free ? ST_IDLE : ST_HOLD;
               end
            end
         end
         ST_POP: begin
            state_in = out_free ? ST_IDLE : ST_HOLD;
         end
         ST_WALK: begin
            if (walk_last) begin
               state_in = ST_WEND;
            end
         end
         ST_WEND: begin
            if (free_any) begin
               state_in = ST_POP;
            end else begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and RAM control
   always_comb begin
      active_in     = active_ff;
      fresh_cnt_in  = fresh_cnt_ff;
      free_head_in  = free_head_ff;
      used_head_in  = used_head_ff;
      cur_in        = cur_ff;
      kept_in       = kept_ff;
      kept_valid_in = kept_valid_ff;
      link_we       = 1'b0;
      link_wa       = '0;
      link_wd       = used_head_ff;
      link_re       = 1'b0;
      link_ra       = free_head_ff[SW-1:0];
      mark_we       = 1'b0;
      mark_wa       = '0;
      mark_wd       = 1'b1;
      mark_re       = 1'b0;
      mark_ra       = link_rd[SW-1:0];
      fin           = 1'b0;
      fin_ok        = 1'b0;
      fin_slot      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (is_mark) begin
                  mark_we  = idx_ok;
                  mark_wa  = SW'(req_slot_index);
                  mark_wd  = req_referenced;
                  fin      = 1'b1;
                  fin_ok   = idx_ok;
                  fin_slot = req_slot_index;
               end else if (fresh_any) begin
                  link_we      = 1'b1;
                  link_wa      = fresh_slot[SW-1:0];
                  mark_we      = 1'b1;
                  mark_wa      = fresh_slot[SW-1:0];
                  used_head_in = fresh_slot;
                  fresh_cnt_in = fresh_slot;
                  fin          = 1'b1;
                  fin_ok       = 1'b1;
                  fin_slot     = SLOT_W'(fresh_slot);
               end else if (free_any) begin
                  link_re = 1'b1;
               end else if (used_any) begin
                  link_re       = 1'b1;
                  link_ra       = used_head_ff[SW-1:0];
                  mark_re       = 1'b1;
                  mark_ra       = used_head_ff[SW-1:0];
                  cur_in        = used_head_ff;
                  kept_valid_in = 1'b0;
               end else begin
                  fin = 1'b1;
               end
            end
         end
         ST_POP: begin
            free_head_in = link_rd;
            link_we      = 1'b1;
            link_wa      = free_head_ff[SW-1:0];
            mark_we      = 1'b1;
            mark_wa      = free_head_ff[SW-1:0];
            used_head_in = free_head_ff;
            fin          = 1'b1;
            fin_ok       = 1'b1;
            fin_slot     = SLOT_W'(free_head_ff);
         end
         ST_WALK: begin
            // link_rd/mark_rd hold the entry of cur_ff
            if (!mark_rd) begin
               link_we      = 1'b1;
               link_wa      = cur_ff[SW-1:0];
               link_wd      = free_head_ff;
               free_head_in = cur_ff;
            end else begin
               // splice past any slots dropped since the last kept one
               if (kept_valid_ff) begin
                  link_we = 1'b1;
                  link_wa = kept_ff[SW-1:0];
                  link_wd = cur_ff;
               end else begin
                  used_head_in = cur_ff;
               end
               kept_in       = cur_ff;
               kept_valid_in = 1'b1;
            end
            if (!walk_last) begin
               link_re = 1'b1;
               link_ra = link_rd[SW-1:0];
               mark_re = 1'b1;
               cur_in  = link_rd;
            end
         end
         ST_WEND: begin
            if (kept_valid_ff) begin
               link_we = 1'b1;
               link_wa = kept_ff[SW-1:0];
               link_wd = LINK_NULL;
            end else begin
               used_head_in = LINK_NULL;
            end
            if (free_any) begin
               link_re = 1'b1;
            end else begin
               fin = 1'b1;
            end
         end
         ST_HOLD: begin
         end
         default: begin
         end
      endcase

      // rebuild: untouched slots form the descending free chain implicitly
      if (csr_wr_en) begin
         active_in    = cfg_sat;
         fresh_cnt_in = cfg_sat;
         free_head_in = LINK_NULL;
         used_head_in = LINK_NULL;
      end
   end

   // response register and holding register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_slot_in  = rsp_slot_ff;
      hold_ok_in   = hold_ok_ff;
      hold_slot_in = hold_slot_ff;
      if (fin && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = fin_ok;
         rsp_slot_in  = fin_slot;
      end else if (fin) begin
         hold_ok_in   = fin_ok;
         hold_slot_in = fin_slot;
      end else if ((state_ff == ST_HOLD) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = hold_ok_ff;
         rsp_slot_in  = hold_slot_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= ACTIVE_RST;
         fresh_cnt_ff  <= ACTIVE_RST;
         free_head_ff  <= LINK_NULL;
         used_head_ff  <= LINK_NULL;
         kept_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         fresh_cnt_ff  <= fresh_cnt_in;
         free_head_ff  <= free_head_in;
         used_head_ff  <= used_head_in;
         kept_valid_ff <= kept_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      kept_ff      <= kept_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_slot_ff  <= rsp_slot_in;
      hold_ok_ff   <= hold_ok_in;
      hold_slot_ff <= hold_slot_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_granted_slot = rsp_slot_ff;

   a_walk_cur_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (cur_ff != LINK_NULL))
      else $error("walk pointer is null");

   a_hold_has_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("holding a result while output register is empty");

   a_fresh_excl_free: assert property (@(posedge clock) disable iff (reset)
      fresh_any |-> (!free_any && (fresh_cnt_ff <= active_ff)))
      else $error("untouched slots coexist with explicit free list");

   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> free_any)
      else $error("pop with empty free list");

endmodule

// ===== rtl/spa_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// No dependencies; used by slot_pool_allocator_lazy_reclaim for links and marks.
module spa_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 7,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
